// ===== rtl/core/bft_pkg.sv =====
// Shared types and constants for the bidirectional flow tracker.
`timescale 1ns / 1ps
`default_nettype none
package bft_pkg;

	localparam int FLOW_ENTRIES = 1024;
	localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
	localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
	localparam int ENTRY_INDEX_W = 10;

	localparam logic [15:0] ETH_IPV4 = 16'h0800;
	localparam logic [3:0] IP_V4 = 4'd4;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	localparam logic [63:0] IDLE_TIMEOUT_RST = 64'd30000000000;
	localparam logic [15:0] WK_PORT_LIMIT_RST = 16'd1024;

	localparam logic REG_IDLE_TIMEOUT = 1'b0;
	localparam logic REG_WK_PORT_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		ACT_IGNORED = 3'd0,
		ACT_NEW = 3'd1,
		ACT_FWD = 3'd2,
		ACT_REV = 3'd3,
		ACT_FWD_RESTART = 3'd4,
		ACT_REV_RESTART = 3'd5,
		ACT_FULL = 3'd6
	} action_t;

	localparam logic [1:0] METH_NONE = 2'd0;
	localparam logic [1:0] METH_SYN = 2'd1;
	localparam logic [1:0] METH_WELL_KNOWN = 2'd2;
	localparam logic [1:0] METH_LOWER_PORT = 2'd3;

	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0] proto;
		logic [63:0] fp;
		logic [63:0] rp;
		logic [63:0] fl;
		logic [63:0] rl;
		logic [63:0] st;
		logic [63:0] ls;
		logic [1:0] method;
		logic [31:0] server;
	} entry_t;

endpackage
`default_nettype wire

// ===== rtl/core/bft_server_pick.sv =====
// Server-side heuristic: SYN flag, well-known port, then lower port.
`timescale 1ns / 1ps
`default_nettype none
module bft_server_pick (
	input wire logic is_tcp,
	input wire logic syn,
	input wire logic ack,
	input wire logic [31:0] src_ip,
	input wire logic [31:0] dst_ip,
	input wire logic [15:0] l4_sport,
	input wire logic [15:0] l4_dport,
	input wire logic [15:0] wk_limit,
	output logic [1:0] method,
	output logic [31:0] server
);

	always_comb begin
		if (is_tcp && syn) begin
			method = bft_pkg::METH_SYN;
			server = ack ? src_ip : dst_ip;
		end else if (l4_dport < wk_limit) begin
			method = bft_pkg::METH_WELL_KNOWN;
			server = dst_ip;
		end else if (l4_sport < wk_limit) begin
			method = bft_pkg::METH_WELL_KNOWN;
			server = src_ip;
		end else begin
			method = bft_pkg::METH_LOWER_PORT;
			server = (l4_dport < l4_sport) ? dst_ip : src_ip;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/bidirectional_flow_tracker.sv =====
// Top level: flow table in one synchronous memory, scanned per transaction.
// An ignored packet skips the probe; a miss scans every slot in use (0 to
// FLOW_ENTRIES) and a hit stops at the match; the probe reads one slot per cycle.
// One transaction in flight; the next one is accepted in the cycle after the
// result is registered.
// Reset clears the fill count and control; the memory is not cleared, no sweep.
`timescale 1ns / 1ps
`default_nettype none
module bidirectional_flow_tracker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [63:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [15:0] ether_type,
	input wire logic [3:0] ip_version,
	input wire logic headers_complete,
	input wire logic [31:0] src_ip,
	input wire logic [31:0] dst_ip,
	input wire logic [15:0] l4_sport,
	input wire logic [15:0] l4_dport,
	input wire logic [7:0] protocol,
	input wire logic tcp_syn,
	input wire logic tcp_ack,
	input wire logic [15:0] ip_total_len,
	input wire logic [63:0] now_ns,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] action,
	output logic [9:0] entry_index,
	output logic [63:0] fwd_packets,
	output logic [63:0] rev_packets,
	output logic [63:0] fwd_length_total,
	output logic [63:0] rev_length_total,
	output logic [63:0] start_time,
	output logic [63:0] last_seen,
	output logic [1:0] server_method,
	output logic [31:0] server_addr
);

	localparam int IW = bft_pkg::IDX_W;
	localparam int CW = bft_pkg::CNT_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PROBE = 4'b0010,
		ST_CALC = 4'b0100,
		ST_UPD = 4'b1000
	} state_t;

	state_t state_q;
	logic [63:0] idle_timeout_q;
	logic [15:0] wk_limit_q;

	logic ign_q, tcp_q, syn_q, ack_q;
	logic [31:0] src_q, dst_q;
	logic [15:0] sport_q, dport_q, len_q;
	logic [7:0] proto_q;
	logic [63:0] now_q;

	logic [CW-1:0] cnt_q, iss_q, raddr_s1;
	logic rv_s1;
	bft_pkg::entry_t mem_q [bft_pkg::FLOW_ENTRIES];
	bft_pkg::entry_t rdata_s1, ent_q, nxt;
	logic rd_en, wr_en, upd_fire, fwd_hit, rev_hit;
	logic [IW-1:0] idx_q;
	bft_pkg::action_t act_q;
	logic [1:0] pick_method;
	logic [31:0] pick_server;

	logic out_valid_q;
	bft_pkg::action_t action_q;
	logic [9:0] entry_index_q;
	bft_pkg::entry_t out_q;

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q <= bft_pkg::IDLE_TIMEOUT_RST;
			wk_limit_q <= bft_pkg::WK_PORT_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bft_pkg::REG_IDLE_TIMEOUT: idle_timeout_q <= cfg_wdata;
				bft_pkg::REG_WK_PORT_LIMIT: wk_limit_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ign_q <= !(ether_type == bft_pkg::ETH_IPV4 && ip_version == bft_pkg::IP_V4 &&
				headers_complete &&
				(protocol == bft_pkg::PROTO_TCP || protocol == bft_pkg::PROTO_UDP));
			tcp_q <= (protocol == bft_pkg::PROTO_TCP);
			syn_q <= tcp_syn;
			ack_q <= tcp_ack;
			src_q <= src_ip;
			dst_q <= dst_ip;
			sport_q <= l4_sport;
			dport_q <= l4_dport;
			proto_q <= protocol;
			len_q <= ip_total_len;
			now_q <= now_ns;
		end
	end

	assign fwd_hit = rdata_s1.src == src_q && rdata_s1.dst == dst_q &&
		rdata_s1.sport == sport_q && rdata_s1.dport == dport_q && rdata_s1.proto == proto_q;
	assign rev_hit = rdata_s1.src == dst_q && rdata_s1.dst == src_q &&
		rdata_s1.sport == dport_q && rdata_s1.dport == sport_q && rdata_s1.proto == proto_q;

	assign rd_en = (state_q == ST_PROBE) && !ign_q && (iss_q < cnt_q) &&
		!(rv_s1 && (fwd_hit || rev_hit));
	assign upd_fire = (state_q == ST_UPD) && (!out_valid_q || out_ready);
	assign wr_en = upd_fire && act_q != bft_pkg::ACT_IGNORED && act_q != bft_pkg::ACT_FULL;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[idx_q] <= nxt;
		end
		if (rd_en) begin
			rdata_s1 <= mem_q[iss_q[IW-1:0]];
		end
	end

	bft_server_pick u_pick (
		.is_tcp(tcp_q),
		.syn(syn_q),
		.ack(ack_q),
		.src_ip(src_q),
		.dst_ip(dst_q),
		.l4_sport(sport_q),
		.l4_dport(dport_q),
		.wk_limit(wk_limit_q),
		.method(pick_method),
		.server(pick_server)
	);

	always_comb begin
		nxt = ent_q;
		case (act_q)
			bft_pkg::ACT_FWD: begin
				nxt.fp = ent_q.fp + 64'd1;
				nxt.fl = ent_q.fl + 64'(len_q);
				nxt.ls = now_q;
			end
			bft_pkg::ACT_REV: begin
				nxt.rp = ent_q.rp + 64'd1;
				nxt.rl = ent_q.rl + 64'(len_q);
				nxt.ls = now_q;
			end
			bft_pkg::ACT_NEW, bft_pkg::ACT_FWD_RESTART, bft_pkg::ACT_REV_RESTART: begin
				if (act_q == bft_pkg::ACT_NEW) begin
					nxt.src = src_q;
					nxt.dst = dst_q;
					nxt.sport = sport_q;
					nxt.dport = dport_q;
					nxt.proto = proto_q;
				end
				if (act_q == bft_pkg::ACT_REV_RESTART) begin
					nxt.fp = 64'd0;
					nxt.fl = 64'd0;
					nxt.rp = 64'd1;
					nxt.rl = 64'(len_q);
				end else begin
					nxt.fp = 64'd1;
					nxt.fl = 64'(len_q);
					nxt.rp = 64'd0;
					nxt.rl = 64'd0;
				end
				nxt.st = now_q;
				nxt.ls = now_q;
				nxt.method = pick_method;
				nxt.server = pick_server;
			end
			default: nxt = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			iss_q <= '0;
			rv_s1 <= 1'b0;
			raddr_s1 <= '0;
			act_q <= bft_pkg::ACT_IGNORED;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rv_s1 <= rd_en;
			if (rd_en) begin
				raddr_s1 <= iss_q;
				iss_q <= iss_q + CW'(1);
			end
			if (upd_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					iss_q <= '0;
					if (in_valid) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (ign_q) begin
						act_q <= bft_pkg::ACT_IGNORED;
						state_q <= ST_UPD;
					end else if (rv_s1 && (fwd_hit || rev_hit)) begin
						act_q <= fwd_hit ? bft_pkg::ACT_FWD : bft_pkg::ACT_REV;
						idx_q <= raddr_s1[IW-1:0];
						state_q <= ST_CALC;
					end else if (cnt_q == '0 || (rv_s1 && raddr_s1 == cnt_q - CW'(1))) begin
						if (cnt_q == CW'(bft_pkg::FLOW_ENTRIES)) begin
							act_q <= bft_pkg::ACT_FULL;
							state_q <= ST_UPD;
						end else begin
							act_q <= bft_pkg::ACT_NEW;
							idx_q <= cnt_q[IW-1:0];
							state_q <= ST_UPD;
						end
					end
				end
				ST_CALC: begin
					if ((now_q - ent_q.ls) > idle_timeout_q) begin
						act_q <= (act_q == bft_pkg::ACT_FWD) ?
							bft_pkg::ACT_FWD_RESTART : bft_pkg::ACT_REV_RESTART;
					end
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_fire) begin
						if (act_q == bft_pkg::ACT_NEW) begin
							cnt_q <= cnt_q + CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PROBE && rv_s1 && (fwd_hit || rev_hit)) begin
			ent_q <= rdata_s1;
		end
		if (upd_fire) begin
			action_q <= act_q;
			entry_index_q <= wr_en ? bft_pkg::ENTRY_INDEX_W'(idx_q) : '0;
			out_q <= nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign action = action_q;
	assign entry_index = entry_index_q;
	assign fwd_packets = out_q.fp;
	assign rev_packets = out_q.rp;
	assign fwd_length_total = out_q.fl;
	assign rev_length_total = out_q.rl;
	assign start_time = out_q.st;
	assign last_seen = out_q.ls;
	assign server_method = out_q.method;
	assign server_addr = out_q.server;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(bft_pkg::FLOW_ENTRIES))
		else $error("fill count exceeds table size");
	a_wr_in_upd: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == ST_UPD)
		else $error("table write outside update");
	a_insert_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && act_q == bft_pkg::ACT_NEW) |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("insert did not advance fill count");
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> iss_q < cnt_q)
		else $error("probe read beyond filled slots");
`endif

endmodule
`default_nettype wire
